/* design/fput_pkg.sv */
`default_nettype none
package fput_pkg;

  typedef enum logic [2:0] {
    CLS_ZERO   = 3'd0,
    CLS_FINITE = 3'd1,
    CLS_INF    = 3'd2,
    CLS_QNAN   = 3'd3,
    CLS_SNAN   = 3'd4
  } class_t;

  typedef enum logic [1:0] {
    FMT_HALF   = 2'd0,
    FMT_SINGLE = 2'd1,
    FMT_DOUBLE = 2'd2,
    FMT_NONE   = 2'd3
  } fmt_t;

  localparam logic CFG_FLUSH = 1'b0;
  localparam logic CFG_ALT   = 1'b1;

  localparam int MANT_W = 53;
  localparam int EXP_W  = 12;
  localparam int CNT_W  = 6;
  localparam int PT_W   = 11;

  localparam logic signed [EXP_W-1:0] HALF_OFS   = 12'sd25;
  localparam logic signed [EXP_W-1:0] SINGLE_OFS = 12'sd150;
  localparam logic signed [EXP_W-1:0] DOUBLE_OFS = 12'sd1075;

  typedef struct packed {
    logic                    negative;
    class_t                  cls;
    logic [MANT_W-1:0]       mant;
    logic signed [EXP_W-1:0] expo;
  } dec_t;

endpackage
`default_nettype wire

/* design/fput_decode.sv */
`default_nettype none
module fput_decode (
  input  wire logic [1:0]    format,
  input  wire logic [63:0]   encoding,
  input  wire logic          flush_subnormals,
  input  wire logic          alt_half_mode,
  output fput_pkg::dec_t     dec
);
  import fput_pkg::*;

  logic                    sgn;
  logic [10:0]             ex;
  logic [10:0]             exmax;
  logic [MANT_W-1:0]       frac;
  logic [MANT_W-1:0]       hidden;
  logic                    topbit;
  logic                    special;
  logic                    flushable;
  logic                    known;
  logic signed [EXP_W-1:0] ofs;
  logic [10:0]             ex_eff;

  always_comb begin
    sgn       = 1'b0;
    ex        = '0;
    exmax     = '0;
    frac      = '0;
    hidden    = '0;
    topbit    = 1'b0;
    special   = 1'b1;
    flushable = 1'b0;
    known     = 1'b1;
    ofs       = HALF_OFS;
    case (fmt_t'(format))
      FMT_HALF: begin
        sgn     = encoding[15];
        ex      = {6'd0, encoding[14:10]};
        frac    = {43'd0, encoding[9:0]};
        exmax   = 11'h1f;
        topbit  = encoding[9];
        hidden  = MANT_W'(1) << 10;
        special = !alt_half_mode;
        ofs     = HALF_OFS;
      end
      FMT_SINGLE: begin
        sgn       = encoding[31];
        ex        = {3'd0, encoding[30:23]};
        frac      = {30'd0, encoding[22:0]};
        exmax     = 11'hff;
        topbit    = encoding[22];
        hidden    = MANT_W'(1) << 23;
        flushable = 1'b1;
        ofs       = SINGLE_OFS;
      end
      FMT_DOUBLE: begin
        sgn       = encoding[63];
        ex        = encoding[62:52];
        frac      = {1'b0, encoding[51:0]};
        exmax     = 11'h7ff;
        topbit    = encoding[51];
        hidden    = MANT_W'(1) << 52;
        flushable = 1'b1;
        ofs       = DOUBLE_OFS;
      end
      default: begin
        known = 1'b0;
      end
    endcase

    ex_eff       = (ex == 11'd0) ? 11'd1 : ex;
    dec.negative = sgn & known;
    dec.mant     = (ex == 11'd0) ? frac : (frac | hidden);
    dec.expo     = $signed({1'b0, ex_eff}) - ofs;
    if (!known) begin
      dec.cls = CLS_ZERO;
    end else if (ex == 11'd0 && (frac == '0 || (flushable && flush_subnormals))) begin
      dec.cls = CLS_ZERO;
    end else if (ex == exmax && special) begin
      if (frac == '0) begin
        dec.cls = CLS_INF;
      end else begin
        dec.cls = topbit ? CLS_QNAN : CLS_SNAN;
      end
    end else begin
      dec.cls = CLS_FINITE;
    end
  end

endmodule
`default_nettype wire

/* design/float_unpack_to_fixed_top.sv */
`default_nettype none
// Channel   Handshake            Payload
// in        in_valid / in_ready  format, encoding
// out       out_valid / out_ready negative, value_class, magnitude, point_position, too_large
// cfg       cfg_write            cfg_index, cfg_data
// Four register stages: decode, bit counts, shift amounts, barrel shift.
// A beat can be accepted every cycle while the output is not stalled (in_ready follows advance).
// Synchronous reset clears the valid bits and both configuration registers.
// A stall at the output holds every stage; no beat is lost or repeated.
module float_unpack_to_fixed_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  format,
  input  wire logic [63:0] encoding,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             negative,
  output logic [2:0]       value_class,
  output logic [63:0]      magnitude,
  output logic [10:0]      point_position,
  output logic             too_large
);
  import fput_pkg::*;

  logic flush_subnormals;
  logic alt_half_mode;
  logic advance;
  logic v1, v2, v3;
  dec_t dec_c, d1, d2;

  logic [CNT_W-1:0] tz_c, msb_c, tz2, msb2;

  logic              neg3, isneg3, big3;
  class_t            cls3;
  logic [MANT_W-1:0] mant3;
  logic [CNT_W-1:0]  shr3, shl3;
  logic [PT_W-1:0]   point3;

  logic [EXP_W-1:0]        nege;
  logic [PT_W-1:0]         ne;
  logic [CNT_W-1:0]        t_c;
  logic signed [EXP_W-1:0] top_c;
  logic [63:0]             m64;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_subnormals <= 1'b0;
      alt_half_mode    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FLUSH: flush_subnormals <= cfg_data;
        CFG_ALT:   alt_half_mode    <= cfg_data;
        default:   ;
      endcase
    end
  end

  fput_decode u_decode (
    .format           (format),
    .encoding         (encoding),
    .flush_subnormals (flush_subnormals),
    .alt_half_mode    (alt_half_mode),
    .dec              (dec_c)
  );

  always_comb begin
    tz_c  = '0;
    msb_c = '0;
    for (int i = MANT_W - 1; i >= 0; i--) begin
      if (d1.mant[i]) tz_c = CNT_W'(i);
    end
    for (int i = 0; i < MANT_W; i++) begin
      if (d1.mant[i]) msb_c = CNT_W'(i);
    end
  end

  always_comb begin
    nege  = -d2.expo;
    ne    = nege[PT_W-1:0];
    t_c   = ({5'd0, tz2} < ne) ? tz2 : ne[CNT_W-1:0];
    top_c = $signed({{(EXP_W-CNT_W){1'b0}}, msb2}) + d2.expo;
  end

  assign m64 = {{(64-MANT_W){1'b0}}, mant3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d1   <= dec_c;
      d2   <= d1;
      tz2  <= tz_c;
      msb2 <= msb_c;

      neg3   <= d2.negative;
      cls3   <= d2.cls;
      mant3  <= d2.mant;
      isneg3 <= d2.expo < 0;
      shr3   <= t_c;
      shl3   <= d2.expo[CNT_W-1:0];
      if (d2.cls != CLS_FINITE) begin
        point3 <= '0;
        big3   <= 1'b0;
      end else if (d2.expo < 0) begin
        point3 <= ne - {5'd0, t_c};
        big3   <= 1'b0;
      end else begin
        point3 <= '0;
        big3   <= (d2.expo >= 12'sd64) || (top_c >= 12'sd64);
      end

      negative       <= neg3;
      value_class    <= cls3;
      point_position <= point3;
      too_large      <= big3;
      if (cls3 != CLS_FINITE || big3) begin
        magnitude <= '0;
      end else if (isneg3) begin
        magnitude <= m64 >> shr3;
      end else begin
        magnitude <= m64 << shl3;
      end
    end
  end

endmodule
`default_nettype wire
